### design/dssm_pkg.sv
package dssm_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_POP_A  = 2'd2,
    CMD_POP_B  = 2'd3
  } cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control sequencer
  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

### design/dual_stack_shared_memory_with_min.sv
// Push, and a pop from an empty stack: result registered at the accepting edge,
// next transaction accepted in the following cycle unless out_ready stalls the result.
// Successful pop: result taken from the registered read of the shared memory, and no
// new command is accepted meanwhile (the min memory is read in parallel in the same cycle).
// Reset (rst, synchronous): stack counts and min count cleared, output empty;
// the memories are not cleared, entries are only read after being written.
module dual_stack_shared_memory_with_min #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic signed [31:0]  push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  pop_data,
  output logic [1:0]          status,
  output logic signed [31:0]  min_value,
  output logic                min_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  // Control state
  dssm_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt_a, cnt_a_next;
  logic [CW-1:0]    cnt_b, cnt_b_next;
  logic [CW-1:0]    min_cnt, min_cnt_next;
  dssm_pkg::word_t  min_top, min_top_next;
  logic             pend_a, pend_a_next;
  logic             out_valid_next;

  // Memory ports
  logic            s_we, m_we;
  logic [CW-1:0]   s_waddr_w, s_raddr_w, m_raddr_w;
  dssm_pkg::word_t s_rdata, m_rdata;

  // Result assembly
  logic               produce;
  dssm_pkg::word_t    res_data;
  dssm_pkg::status_t  res_status;
  dssm_pkg::cmd_t     cmd;
  logic               accept;
  logic               full;
  logic               min_take;
  logic               pop_ok;

  assign cmd    = dssm_pkg::cmd_t'(command);
  assign accept = in_valid && in_ready;
  assign full   = ({1'b0, cnt_a} + {1'b0, cnt_b}) >= {1'b0, DEPTH_C};
  assign min_take = (min_cnt == '0) || (push_value <= min_top);
  assign pop_ok = ((cmd == dssm_pkg::CMD_POP_A) && (cnt_a != '0)) ||
                  ((cmd == dssm_pkg::CMD_POP_B) && (cnt_b != '0));

  // Memory addresses
  always_comb begin
    if (cmd == dssm_pkg::CMD_PUSH_A) begin
      s_waddr_w = cnt_a;
    end else begin
      s_waddr_w = DEPTH_C - ONE_C - cnt_b;
    end
    if (cmd == dssm_pkg::CMD_POP_A) begin
      s_raddr_w = cnt_a - ONE_C;
    end else begin
      s_raddr_w = DEPTH_C - cnt_b;
    end
    m_raddr_w = min_cnt - TWO_C;
  end

  dssm_ram #(.DEPTH(DEPTH), .WIDTH(dssm_pkg::DATA_W), .AW(AW)) u_shared (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr_w[AW-1:0]),
    .wdata (push_value),
    .raddr (s_raddr_w[AW-1:0]),
    .rdata (s_rdata)
  );

  dssm_ram #(.DEPTH(DEPTH), .WIDTH(dssm_pkg::DATA_W), .AW(AW)) u_min (
    .clk   (clk),
    .we    (m_we),
    .waddr (min_cnt[AW-1:0]),
    .wdata (push_value),
    .raddr (m_raddr_w[AW-1:0]),
    .rdata (m_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dssm_pkg::S_IDLE: begin
        if (accept && pop_ok) begin
          state_next = dssm_pkg::S_POP;
        end
      end
      dssm_pkg::S_POP: state_next = dssm_pkg::S_IDLE;
      default: state_next = dssm_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    case (state)
      dssm_pkg::S_IDLE: in_ready = !out_valid || out_ready;
      default:          in_ready = 1'b0;
    endcase
  end

  // Datapath: counts, memory writes, result
  always_comb begin
    cnt_a_next   = cnt_a;
    cnt_b_next   = cnt_b;
    min_cnt_next = min_cnt;
    min_top_next = min_top;
    pend_a_next  = pend_a;
    s_we         = 1'b0;
    m_we         = 1'b0;
    produce      = 1'b0;
    res_data     = '0;
    res_status   = dssm_pkg::ST_OK;
    if (state == dssm_pkg::S_IDLE && accept) begin
      case (cmd)
        dssm_pkg::CMD_PUSH_A: begin
          produce = 1'b1;
          if (full) begin
            res_status = dssm_pkg::ST_OVERFLOW;
          end else begin
            s_we       = 1'b1;
            cnt_a_next = cnt_a + ONE_C;
            if (min_take && (min_cnt < DEPTH_C)) begin
              m_we         = 1'b1;
              min_cnt_next = min_cnt + ONE_C;
              min_top_next = push_value;
            end
          end
        end
        dssm_pkg::CMD_PUSH_B: begin
          produce = 1'b1;
          if (full) begin
            res_status = dssm_pkg::ST_OVERFLOW;
          end else begin
            s_we       = 1'b1;
            cnt_b_next = cnt_b + ONE_C;
          end
        end
        dssm_pkg::CMD_POP_A: begin
          if (cnt_a == '0) begin
            produce    = 1'b1;
            res_status = dssm_pkg::ST_UNDERFLOW;
            res_data   = dssm_pkg::INT_MIN;
          end else begin
            cnt_a_next  = cnt_a - ONE_C;
            pend_a_next = 1'b1;
          end
        end
        default: begin
          if (cnt_b == '0) begin
            produce    = 1'b1;
            res_status = dssm_pkg::ST_UNDERFLOW;
            res_data   = dssm_pkg::INT_MIN;
          end else begin
            cnt_b_next  = cnt_b - ONE_C;
            pend_a_next = 1'b0;
          end
        end
      endcase
    end else if (state == dssm_pkg::S_POP) begin
      // read data from the accepting edge is now available
      produce  = 1'b1;
      res_data = s_rdata;
      if (pend_a && (min_cnt != '0) && (s_rdata == min_top)) begin
        min_cnt_next = min_cnt - ONE_C;
        min_top_next = m_rdata;
      end
    end
  end

  assign out_valid_next = produce || (out_valid && !out_ready);

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dssm_pkg::S_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      min_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      min_cnt   <= min_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    min_top <= min_top_next;
    pend_a  <= pend_a_next;
    if (produce) begin
      pop_data  <= res_data;
      status    <= res_status;
      min_valid <= (min_cnt_next != '0);
      min_value <= (min_cnt_next != '0) ? min_top_next : dssm_pkg::INT_MIN;
    end
  end

endmodule

### design/dssm_ram.sv
module dssm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/dssm_checker.sv
module dssm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         command,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pop_data,
  input logic [1:0]         status,
  input logic signed [31:0] min_value,
  input logic               min_valid
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pop_data) && $stable(status))
    else $error("result changed while stalled");

  // A push always returns its result right after acceptance
  a_push_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == dssm_pkg::CMD_PUSH_A ||
    command == dssm_pkg::CMD_PUSH_B) |=> out_valid)
    else $error("push result late");

  // Underflow returns the most negative value
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dssm_pkg::ST_UNDERFLOW |-> pop_data == dssm_pkg::INT_MIN)
    else $error("underflow data wrong");

  // Overflowed push results carry zero data
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dssm_pkg::ST_OVERFLOW |-> pop_data == '0)
    else $error("overflow data nonzero");

  // Empty min stack reports the most negative value
  a_min_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !min_valid |-> min_value == dssm_pkg::INT_MIN)
    else $error("min value without min_valid");

endmodule

bind dual_stack_shared_memory_with_min dssm_checker u_dssm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pop_data  (pop_data),
  .status    (status),
  .min_value (min_value),
  .min_valid (min_valid)
);
